>>> sv/slkt_pkg.sv
// Shared types, constants and microcode program of the sorted leaf key table.
package slkt_pkg;

  localparam int MAX_CELLS_DEF = 16;
  localparam int KEY_BITS_DEF  = 32;

  localparam int ACTION_W = 2;
  localparam int SKEY_W   = 32;
  localparam int POS_W    = 5;
  localparam int ROW_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FIND   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BEYOND = 2'd2
  } status_t;

  // Datapath operation selected by one control word.
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_INIT    = 4'd1,
    OP_INSCHK  = 4'd2,
    OP_RDPREV  = 4'd3,
    OP_WRSHIFT = 4'd4,
    OP_WRNEW   = 4'd5,
    OP_RDMID   = 4'd6,
    OP_CMP     = 4'd7,
    OP_MISS    = 4'd8,
    OP_CLEAR   = 4'd9,
    OP_EMIT    = 4'd10
  } uop_t;

  // Jump conditions tested by the sequencer.
  typedef enum logic [3:0] {
    C_ALWAYS      = 4'd0,
    C_IN_ACC      = 4'd1,
    C_ACT_FIND    = 4'd2,
    C_ACT_NOT_INS = 4'd3,
    C_REJECT      = 4'd4,
    C_IDX_LE_POS  = 4'd5,
    C_LO_GE_HI    = 4'd6,
    C_NE          = 4'd7,
    C_OUT_FREE    = 4'd8
  } cond_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Program addresses.
  localparam upc_t ST_IDLE   = 4'd0;
  localparam upc_t ST_DFIND  = 4'd1;
  localparam upc_t ST_DINS   = 4'd2;
  localparam upc_t ST_ICHK   = 4'd3;
  localparam upc_t ST_ISRD   = 4'd4;
  localparam upc_t ST_ISWR   = 4'd5;
  localparam upc_t ST_IWR    = 4'd6;
  localparam upc_t ST_FPROBE = 4'd7;
  localparam upc_t ST_FCMP   = 4'd8;
  localparam upc_t ST_EMIT   = 4'd9;
  localparam upc_t ST_FMISS  = 4'd10;
  localparam upc_t ST_OTHER  = 4'd11;

  // A taken condition jumps to target; otherwise the step counter holds when
  // hold is set and advances by one when it is not.
  typedef struct packed {
    uop_t  op;
    cond_t cond;
    logic  hold;
    upc_t  target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input upc_t addr);
    ctrl_word_t cw;
    unique case (addr)
      ST_IDLE:   cw = '{OP_NOP,     C_IN_ACC,      1'b1, ST_DFIND};
      ST_DFIND:  cw = '{OP_INIT,    C_ACT_FIND,    1'b0, ST_FPROBE};
      ST_DINS:   cw = '{OP_NOP,     C_ACT_NOT_INS, 1'b0, ST_OTHER};
      ST_ICHK:   cw = '{OP_INSCHK,  C_REJECT,      1'b0, ST_EMIT};
      ST_ISRD:   cw = '{OP_RDPREV,  C_IDX_LE_POS,  1'b0, ST_IWR};
      ST_ISWR:   cw = '{OP_WRSHIFT, C_ALWAYS,      1'b0, ST_ISRD};
      ST_IWR:    cw = '{OP_WRNEW,   C_ALWAYS,      1'b0, ST_EMIT};
      ST_FPROBE: cw = '{OP_RDMID,   C_LO_GE_HI,    1'b0, ST_FMISS};
      ST_FCMP:   cw = '{OP_CMP,     C_NE,          1'b0, ST_FPROBE};
      ST_EMIT:   cw = '{OP_EMIT,    C_OUT_FREE,    1'b1, ST_IDLE};
      ST_FMISS:  cw = '{OP_MISS,    C_ALWAYS,      1'b0, ST_EMIT};
      ST_OTHER:  cw = '{OP_CLEAR,   C_ALWAYS,      1'b0, ST_EMIT};
      default:   cw = '{OP_NOP,     C_ALWAYS,      1'b0, ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> sv/slkt_in_if.sv
// Valid/ready channel that carries one leaf table request.
interface slkt_in_if import slkt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SKEY_W-1:0]   search_key;
  logic [POS_W-1:0]    insert_position;
  logic [ROW_W-1:0]    row_word;

  modport source (output valid, action, search_key, insert_position, row_word,
                  input ready);
  modport sink   (input valid, action, search_key, insert_position, row_word,
                  output ready);
endinterface

>>> sv/slkt_out_if.sv
// Valid/ready channel that carries one leaf table result.
interface slkt_out_if import slkt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [POS_W-1:0]    cell_position;
  logic [ROW_W-1:0]    row_out;
  logic [COUNT_W-1:0]  cell_count;

  modport source (output valid, status, found, cell_position, row_out, cell_count,
                  input ready);
  modport sink   (input valid, status, found, cell_position, row_out, cell_count,
                  output ready);
endinterface

>>> sv/slkt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module slkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/sorted_leaf_key_table_core.sv
// Sorted leaf key table: microcoded find, insert and clear over one leaf RAM.
//
// Requests arrive on in_ch (valid/ready) carrying an action, a key, an insert
// position and a row word; each request yields exactly one result on out_ch.
// A find binary-searches the cells in use and returns the match position and
// its row word, or the insertion point. An insert moves the cells at and above
// its position up one place and writes the new pair; a full leaf or a
// position above the count is rejected with a status and leaves the table as
// it was. A clear empties the leaf.
// A find makes at most ceil(log2(MAX_CELLS + 1)) probes; each probe and each
// insert move waits for the registered read of the single leaf RAM read port.
// in_ch.ready is high only while the sequencer is idle; one request is in work
// at a time. A result waits in the output register while out_ch is stalled,
// and the sequencer holds at its emit step until that register is free.
// Reset empties the leaf (count zero) and idles the sequencer; the RAM
// contents are not cleared, and no cell is used before it has been written.
module sorted_leaf_key_table_core import slkt_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  slkt_in_if.sink     in_ch,
  slkt_out_if.source  out_ch
);
  localparam int AW     = $clog2(MAX_CELLS);
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int WORD_W = KEY_BITS + ROW_W;

  // Sequencer.
  upc_t       upc_r, upc_nxt;
  ctrl_word_t cw;
  logic       cond_true;

  // Request registers.
  action_t               act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [POS_W-1:0]      pos_r;
  logic [ROW_W-1:0]      row_r;

  // Datapath state.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [CNT_W:0]   mid_sum;

  // Result being built and the output register.
  status_t          res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic [ROW_W-1:0] res_row_r, res_row_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             emit_fire;

  // Leaf RAM port signals; a word holds the key above the row word.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [ROW_W-1:0]    rd_row;

  logic in_acc;
  logic leaf_full, pos_beyond, key_eq, key_lt;
  logic [CMP_W-1:0] pos_w, cnt_w, idx_w;

  slkt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_CELLS)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (upc_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign rd_key = ram_rdata[WORD_W-1:ROW_W];
  assign rd_row = ram_rdata[ROW_W-1:0];

  assign pos_w      = CMP_W'(pos_r);
  assign cnt_w      = CMP_W'(cnt_r);
  assign idx_w      = CMP_W'(idx_r);
  assign leaf_full  = (cnt_r == CNT_W'(MAX_CELLS));
  assign pos_beyond = (pos_w > cnt_w);
  assign key_eq     = (key_r == rd_key);
  assign key_lt     = (key_r < rd_key);

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_nxt = mid_sum[AW:1];

  assign cw        = ucode_rom(upc_r);
  assign emit_fire = (cw.op == OP_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:      cond_true = 1'b1;
      C_IN_ACC:      cond_true = in_acc;
      C_ACT_FIND:    cond_true = (act_r == ACT_FIND);
      C_ACT_NOT_INS: cond_true = (act_r != ACT_INSERT);
      C_REJECT:      cond_true = leaf_full || pos_beyond;
      C_IDX_LE_POS:  cond_true = (idx_w <= pos_w);
      C_LO_GE_HI:    cond_true = (lo_r >= hi_r);
      C_NE:          cond_true = !key_eq;
      C_OUT_FREE:    cond_true = !out_valid_r || out_ch.ready;
      default:       cond_true = 1'b0;
    endcase
  end

  always_comb begin
    priority if (cond_true) begin
      upc_nxt = cw.target;
    end else if (cw.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + upc_t'(1);
    end
  end

  // Datapath controlled by the current control word.
  always_comb begin
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    res_row_nxt    = res_row_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_raddr      = mid_nxt;
    unique case (cw.op)
      OP_INIT: begin
        lo_nxt  = '0;
        hi_nxt  = cnt_r;
        idx_nxt = cnt_r;
      end
      OP_INSCHK: begin
        priority if (leaf_full) begin
          res_status_nxt = STAT_FULL;
        end else if (pos_beyond) begin
          res_status_nxt = STAT_BEYOND;
        end else begin
          res_status_nxt = STAT_OK;
        end
        res_found_nxt = 1'b0;
        res_pos_nxt   = pos_r;
        res_row_nxt   = '0;
      end
      OP_RDPREV: begin
        ram_raddr = AW'(idx_r - CNT_W'(1));
      end
      OP_WRSHIFT: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r - CNT_W'(1);
      end
      OP_WRNEW: begin
        ram_we    = 1'b1;
        ram_waddr = pos_w[AW-1:0];
        ram_wdata = {key_r, row_r};
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      OP_CMP: begin
        priority if (key_eq) begin
          res_status_nxt = STAT_OK;
          res_found_nxt  = 1'b1;
          res_pos_nxt    = POS_W'(mid_r);
          res_row_nxt    = rd_row;
        end else if (key_lt) begin
          hi_nxt = CNT_W'(mid_r);
        end else begin
          lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
        end
      end
      OP_MISS: begin
        res_status_nxt = STAT_OK;
        res_found_nxt  = 1'b0;
        res_pos_nxt    = POS_W'(lo_r);
        res_row_nxt    = '0;
      end
      OP_CLEAR: begin
        // Unused action code falls here too and leaves the count alone.
        if (act_r == ACT_CLEAR) begin
          cnt_nxt = '0;
        end
        res_status_nxt = STAT_OK;
        res_found_nxt  = 1'b0;
        res_pos_nxt    = '0;
        res_row_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    priority if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= action_t'(in_ch.action);
      key_r <= KEY_BITS'(in_ch.search_key);
      pos_r <= in_ch.insert_position;
      row_r <= in_ch.row_word;
    end
    if (cw.op == OP_RDMID) begin
      mid_r <= mid_nxt;
    end
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_pos_r    <= res_pos_nxt;
    res_row_r    <= res_row_nxt;
    if (emit_fire) begin
      out_ch.status        <= res_status_r;
      out_ch.found         <= res_found_r;
      out_ch.cell_position <= res_pos_r;
      out_ch.row_out       <= res_row_r;
      out_ch.cell_count    <= COUNT_W'(cnt_r);
    end
  end

  assign out_ch.valid = out_valid_r;

  // The count never passes the capacity of the leaf.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CELLS))
    else $error("cell count above capacity");

  // Every RAM write lands at or below the current count.
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CMP_W'(ram_waddr) <= cnt_w))
    else $error("leaf write beyond the cells in use");

  // An emitted result is presented and the sequencer returns to idle.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (out_valid_r && (upc_r == ST_IDLE)))
    else $error("emit did not present a result and idle");

  // The count moves only on a completed insert or a clear step.
  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> ($past(cw.op) == OP_WRNEW || $past(cw.op) == OP_CLEAR))
    else $error("cell count changed outside insert or clear");

endmodule

>>> test/sorted_leaf_key_table_core_tb.sv
// Self-checking testbench for the sorted leaf key table core.
`timescale 1ns / 100ps

module sorted_leaf_key_table_core_tb;
  import slkt_pkg::*;

  localparam int CELLS = MAX_CELLS_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SKEY_W-1:0]   key;
    logic [POS_W-1:0]    pos;
    logic [ROW_W-1:0]    row;
  } leaf_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [POS_W-1:0]    pos;
    logic [ROW_W-1:0]    row;
    logic [COUNT_W-1:0]  count;
  } leaf_result_t;

  typedef struct {
    leaf_req_t    req;
    bit           typed;
    leaf_result_t res;
  } steer_row_t;

  logic clk;
  logic rst_n;

  slkt_in_if  in_if ();
  slkt_out_if out_if ();

  sorted_leaf_key_table_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Mirror of the leaf contents as the block should hold them.
  logic [SKEY_W-1:0] leaf_keys [CELLS];
  logic [ROW_W-1:0]  leaf_rows [CELLS];
  int                leaf_count;

  leaf_result_t pending_results [$];
  steer_row_t   steer_table [$];
  int           mismatch_count;
  int           tx_idle_pct;
  int           rx_idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Binary search over the cells in use; idx is the match or the insertion point.
  function automatic void search_leaf(input logic [SKEY_W-1:0] key, output bit hit,
                                      output int idx);
    int lo;
    int hi;
    int mid;
    lo  = 0;
    hi  = leaf_count;
    hit = 1'b0;
    idx = 0;
    while (lo < hi && !hit) begin
      mid = (lo + hi) / 2;
      if (key == leaf_keys[mid]) begin
        hit = 1'b1;
        idx = mid;
      end else if (key < leaf_keys[mid]) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    if (!hit) idx = lo;
  endfunction

  function automatic leaf_result_t apply_leaf_request(input leaf_req_t rq);
    leaf_result_t rs;
    bit           hit;
    int           idx;
    rs = '0;
    if (rq.action == ACT_FIND) begin
      search_leaf(rq.key, hit, idx);
      rs.found = hit;
      rs.pos   = idx[POS_W-1:0];
      if (hit) rs.row = leaf_rows[idx];
    end else if (rq.action == ACT_INSERT) begin
      rs.pos = rq.pos;
      // A full leaf is reported even when the position is also out of range.
      if (leaf_count >= CELLS) begin
        rs.status = STAT_FULL;
      end else if (int'(rq.pos) > leaf_count) begin
        rs.status = STAT_BEYOND;
      end else begin
        for (int i = leaf_count; i > int'(rq.pos); i--) begin
          leaf_keys[i] = leaf_keys[i-1];
          leaf_rows[i] = leaf_rows[i-1];
        end
        leaf_keys[rq.pos] = rq.key;
        leaf_rows[rq.pos] = rq.row;
        leaf_count++;
      end
    end else if (rq.action == ACT_CLEAR) begin
      leaf_count = 0;
    end
    rs.count = leaf_count[COUNT_W-1:0];
    return rs;
  endfunction

  // Drives one request and waits for its transaction; valid is left high so a
  // back-to-back request needs no second assignment in the same step.
  task automatic send_req(input leaf_req_t rq, input bit typed, input leaf_result_t typed_res);
    leaf_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.action          <= rq.action;
    in_if.search_key      <= rq.key;
    in_if.insert_position <= rq.pos;
    in_if.row_word        <= rq.row;
    do @(posedge clk); while (!in_if.ready);
    predicted = apply_leaf_request(rq);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic add_row(input logic [ACTION_W-1:0] act, input logic [SKEY_W-1:0] key,
                         input logic [POS_W-1:0] pos, input logic [ROW_W-1:0] row,
                         input bit typed, input logic [STATUS_W-1:0] st,
                         input logic fnd, input logic [POS_W-1:0] cp,
                         input logic [ROW_W-1:0] ro, input logic [COUNT_W-1:0] cc);
    steer_row_t r;
    r.req   = '{act, key, pos, row};
    r.typed = typed;
    r.res   = '{st, fnd, cp, ro, cc};
    steer_table.push_back(r);
  endtask

  function automatic logic [SKEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return '0;
    if (sel < 8) return '1;
    // Narrow keys make duplicates and exact hits common.
    if (sel < 35) return SKEY_W'($urandom_range(31));
    return $urandom;
  endfunction

  // Mostly well-formed find-then-insert sequences that fill the leaf, with
  // finds of stored keys, occasional clears, and some broken or noise requests.
  task automatic run_random(input int n_items);
    int        sent;
    int        sel;
    int        idx;
    bit        hit;
    leaf_req_t rq;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      rq.row = $urandom;
      if (sel < 6) begin
        rq.action = ACTION_W'($urandom_range(3));
        rq.key    = $urandom;
        rq.pos    = POS_W'($urandom_range(31));
        send_req(rq, 1'b0, '0);
        sent++;
      end else if (sel < 9) begin
        rq = '{ACT_CLEAR, $urandom, POS_W'($urandom_range(31)), $urandom};
        send_req(rq, 1'b0, '0);
        sent++;
      end else if (sel < 16) begin
        rq = '{ACT_INSERT, pick_key(), POS_W'($urandom_range(31)), $urandom};
        send_req(rq, 1'b0, '0);
        sent++;
      end else if (sel < 45) begin
        rq.action = ACT_FIND;
        rq.pos    = POS_W'($urandom_range(31));
        if (leaf_count > 0 && $urandom_range(1)) begin
          rq.key = leaf_keys[$urandom_range(leaf_count - 1)];
        end else begin
          rq.key = pick_key();
        end
        send_req(rq, 1'b0, '0);
        sent++;
      end else begin
        rq.action = ACT_FIND;
        rq.key    = pick_key();
        rq.pos    = POS_W'($urandom_range(31));
        send_req(rq, 1'b0, '0);
        search_leaf(rq.key, hit, idx);
        rq.action = ACT_INSERT;
        rq.pos    = idx[POS_W-1:0];
        send_req(rq, 1'b0, '0);
        sent += 2;
      end
    end
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    leaf_result_t got;
    leaf_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.status, out_if.found, out_if.cell_position, out_if.row_out,
              out_if.cell_count};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d found %0d pos %0d row %h count %0d",
                   got.status, got.found, got.pos, got.row, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.pos !== want.pos || got.row !== want.row || got.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d found %0d pos %0d row %h count %0d",
                     want.status, want.found, want.pos, want.row, want.count);
            $display("          actual   status %0d found %0d pos %0d row %h count %0d",
                     got.status, got.found, got.pos, got.row, got.count);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.action          = '0;
    in_if.search_key      = '0;
    in_if.insert_position = '0;
    in_if.row_word        = '0;
    mismatch_count        = 0;
    leaf_count            = 0;
    tx_idle_pct           = 21;
    rx_idle_pct           = 62;
    for (int i = 0; i < CELLS; i++) begin
      leaf_keys[i] = '0;
      leaf_rows[i] = '0;
    end

    add_row(ACT_FIND,   32'h0,        5'd0,  32'h0,        1, STAT_OK,     0, 5'd0,  32'h0, 5'd0);
    add_row(ACT_FIND,   32'hFFFFFFFF, 5'd31, 32'hFFFFFFFF, 1, STAT_OK,     0, 5'd0,  32'h0, 5'd0);
    add_row(ACT_INSERT, 32'h5,        5'd1,  32'h1,        1, STAT_BEYOND, 0, 5'd1,  32'h0, 5'd0);
    add_row(ACT_INSERT, 32'h5,        5'd31, 32'h1,        1, STAT_BEYOND, 0, 5'd31, 32'h0, 5'd0);
    add_row(ACT_INSERT, 32'h0,        5'd0,  32'hFFFFFFFF, 1, STAT_OK,     0, 5'd0,  32'h0, 5'd1);
    add_row(ACT_INSERT, 32'hFFFFFFFF, 5'd1,  32'h0,        1, STAT_OK,     0, 5'd1,  32'h0, 5'd2);
    add_row(ACT_FIND,   32'h0,        5'd0,  32'h0,        1, STAT_OK, 1, 5'd0, 32'hFFFFFFFF, 5'd2);
    add_row(ACT_FIND,   32'hFFFFFFFF, 5'd0,  32'h0,        1, STAT_OK,     1, 5'd1,  32'h0, 5'd2);
    add_row(ACT_INSERT, 32'h80000000, 5'd1,  32'hA5A55A5A, 0, STAT_OK,     0, 5'd0,  32'h0, 5'd0);
    add_row(ACT_FIND,   32'h80000000, 5'd0,  32'h0,        0, STAT_OK,     0, 5'd0,  32'h0, 5'd0);
    add_row(ACT_FIND,   32'h7FFFFFFF, 5'd0,  32'h0,        0, STAT_OK,     0, 5'd0,  32'h0, 5'd0);
    add_row(ACT_INSERT, 32'h1,        5'd4,  32'h1,        1, STAT_BEYOND, 0, 5'd4,  32'h0, 5'd3);
    // The unused action code leaves the leaf untouched and reports the count.
    add_row(ACT_UNUSED, 32'hFFFFFFFF, 5'd31, 32'hFFFFFFFF, 1, STAT_OK,     0, 5'd0,  32'h0, 5'd3);
    add_row(ACT_CLEAR,  32'hFFFFFFFF, 5'd31, 32'hFFFFFFFF, 1, STAT_OK,     0, 5'd0,  32'h0, 5'd0);
    add_row(ACT_FIND,   32'h80000000, 5'd0,  32'h0,        1, STAT_OK,     0, 5'd0,  32'h0, 5'd0);
    add_row(ACT_INSERT, 32'h1234,     5'd0,  32'h5678,     0, STAT_OK,     0, 5'd0,  32'h0, 5'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steer_table[i]) send_req(steer_table[i].req, steer_table[i].typed,
                                      steer_table[i].res);

    run_random(180);
    drain_results();
    tx_idle_pct = 62;
    rx_idle_pct = 21;
    run_random(180);
    drain_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(180);
    drain_results();
    repeat (50) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
